// File: sv/great_circle_initial_bearing_assert.svh
// ----------------------------------------------------------------------------
// great circle bearing assertion macros
// implication checks that are compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef GREAT_CIRCLE_INITIAL_BEARING_ASSERT_SVH
`define GREAT_CIRCLE_INITIAL_BEARING_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define GCIB_ASSERT_NOW(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("gcib same-cycle check failed");
// next-cycle implication
`define GCIB_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("gcib next-cycle check failed");
`else
`define GCIB_ASSERT_NOW(label, clk, rst, lhs, rhs)
`define GCIB_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif
`endif

// File: sv/gcib_pkg.sv
// ----------------------------------------------------------------------------
// gcib_pkg
// widths, cordic constants and the elaboration-time arctangent table
// ----------------------------------------------------------------------------
package gcib_pkg;

  localparam int ITER       = 31;
  localparam int FIELD_BITS = 32;
  localparam int SC_W       = 33;  // q30 sine/cosine with headroom
  localparam int VEC_W      = 44;  // q40 atan2 operands with cordic growth

  localparam logic [63:0] PI_Q60          = 64'h3243F6A8885A308D;
  localparam logic [63:0] TWO_OVER_PI_Q64 = 64'hA2F9836E4E441529;
  localparam logic signed [SC_W-1:0] GAIN_Q30 = 33'sh026DD3B6A;

  // shift-subtract divide, elaboration only
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in q60 radians by series
  function automatic logic [63:0] atan_q60(int i);
    logic [63:0] sum;
    logic [63:0] term;
    int e;
    sum = '0;
    if (i == 0) return PI_Q60 >> 2;
    for (int k = 0; k < 31; k++) begin
      e = 60 - i * (2 * k + 1);
      if (e >= 0) begin
        term = udiv64(64'd1 << e, 64'(2 * k + 1));
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
    end
    return sum;
  endfunction

  // table entry in binary-angle units of an ab-bit angle register
  function automatic logic [63:0] atan_ang(int i, int ab);
    logic [127:0] p;
    logic [63:0] q;
    p = {64'd0, atan_q60(i)} * {64'd0, TWO_OVER_PI_Q64};
    q = p[127:64];
    return (q + (64'd1 << (61 - ab))) >> (62 - ab);
  endfunction

endpackage

// File: sv/gcib_rot_cell.sv
// ----------------------------------------------------------------------------
// gcib_rot_cell
// one rotation-mode cordic micro-step, registered
// ----------------------------------------------------------------------------
module gcib_rot_cell
  import gcib_pkg::*;
#(
  parameter int ANGLE_BITS = 32,
  parameter int STAGE = 0,
  parameter logic [ANGLE_BITS-1:0] ATAN = '0
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [SC_W-1:0]       x_in,
  input  logic signed [SC_W-1:0]       y_in,
  input  logic [ANGLE_BITS-1:0]        z_in,
  input  logic                         neg_in,
  output logic signed [SC_W-1:0]       x_out,
  output logic signed [SC_W-1:0]       y_out,
  output logic [ANGLE_BITS-1:0]        z_out,
  output logic                         neg_out
);

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[ANGLE_BITS-1]) begin
        x_out <= x_in - (y_in >>> STAGE);
        y_out <= y_in + (x_in >>> STAGE);
        z_out <= z_in - ATAN;
      end else begin
        x_out <= x_in + (y_in >>> STAGE);
        y_out <= y_in - (x_in >>> STAGE);
        z_out <= z_in + ATAN;
      end
      neg_out <= neg_in;
    end
  end

endmodule

// File: sv/gcib_vec_cell.sv
// ----------------------------------------------------------------------------
// gcib_vec_cell
// one vectoring-mode cordic micro-step, registered
// ----------------------------------------------------------------------------
module gcib_vec_cell
  import gcib_pkg::*;
#(
  parameter int ANGLE_BITS = 32,
  parameter int STAGE = 0,
  parameter logic [ANGLE_BITS-1:0] ATAN = '0
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [VEC_W-1:0]      x_in,
  input  logic signed [VEC_W-1:0]      y_in,
  input  logic [ANGLE_BITS-1:0]        z_in,
  input  logic                         zero_in,
  output logic signed [VEC_W-1:0]      x_out,
  output logic signed [VEC_W-1:0]      y_out,
  output logic [ANGLE_BITS-1:0]        z_out,
  output logic                         zero_out
);

  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[VEC_W-1]) begin
        x_out <= x_in + (y_in >>> STAGE);
        y_out <= y_in - (x_in >>> STAGE);
        z_out <= z_in + ATAN;
      end else begin
        x_out <= x_in - (y_in >>> STAGE);
        y_out <= y_in + (x_in >>> STAGE);
        z_out <= z_in - ATAN;
      end
      zero_out <= zero_in;
    end
  end

endmodule

// File: sv/great_circle_initial_bearing.sv
// ----------------------------------------------------------------------------
// great_circle_initial_bearing
// initial great-circle bearing between two points, fixed-point cordic pipeline
// ----------------------------------------------------------------------------
// Takes a start and an end point as binary angles (2^31 = 180 degrees) and
// returns the initial bearing clockwise from north in the same format. One
// beat is accepted every clock cycle while the pipe is not held; each beat
// passes 2*31+6 = 68 registers on its way to the output register. The
// depth is set by the two chains of 31 cordic cells (three parallel
// rotation chains for the sines and cosines, then one vectoring chain for
// atan2) plus the input, three multiply, the pre-rotation and the output
// registers. The whole pipe holds while a result waits under stall. A bearing
// whose two components are both zero gives 0; due south reads as -2^31.
module great_circle_initial_bearing
  import gcib_pkg::*;
#(
  parameter int ANGLE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [FIELD_BITS-1:0] start_lat,
  input  logic signed [FIELD_BITS-1:0] start_lon,
  input  logic signed [FIELD_BITS-1:0] end_lat,
  input  logic signed [FIELD_BITS-1:0] end_lon,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [FIELD_BITS-1:0] initial_bearing
);

  `include "great_circle_initial_bearing_assert.svh"

  localparam int AB   = ANGLE_BITS;
  localparam int UPSH = (AB >= FIELD_BITS) ? AB - FIELD_BITS : 0;
  localparam int DNSH = (AB < FIELD_BITS) ? FIELD_BITS - AB : 0;
  localparam int LAT  = 2 * ITER + 6;
  localparam int ROT_END = ITER + 1;     // index of first multiply stage
  localparam int VEC_BEG = ITER + 5;     // index of first vectoring cell
  localparam logic signed [AB:0] QT = (AB + 1)'(1) <<< (AB - 2);
  localparam logic signed [AB:0] HT = (AB + 1)'(1) <<< (AB - 1);
  localparam logic [63:0] AMASK = (64'd1 << AB) - 64'd1;
  localparam logic [63:0] HALFR = (64'd1 << UPSH) >> 1;

  // pipeline advance: everything moves unless the result is held
  logic           en;
  logic [LAT-1:0] vld;

  assign en        = !(vld[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // field to angle register: scale up or floor-shift down
  function automatic logic [AB-1:0] to_ang(logic signed [FIELD_BITS-1:0] f);
    logic signed [63:0] w;
    w = 64'(f);
    w = (w <<< UPSH) >>> DNSH;
    return w[AB-1:0];
  endfunction

  // fold into the quarter turns either side of zero
  function automatic logic [AB:0] fold(logic [AB-1:0] a);
    logic signed [AB:0] z;
    logic               n;
    z = {a[AB-1], a};
    n = 1'b0;
    if (z > QT) begin
      z = z - HT;
      n = 1'b1;
    end else if (z < -QT) begin
      z = z + HT;
      n = 1'b1;
    end
    return {n, z[AB-1:0]};
  endfunction

  // input stage: angles, longitude difference, fold
  logic [AB-1:0] lat1_a, lat2_a, dlon_a;
  logic [AB:0]   f1, f2, fd;

  always_comb begin
    lat1_a = to_ang(start_lat);
    lat2_a = to_ang(end_lat);
    dlon_a = to_ang(end_lon) - to_ang(start_lon);  // wraps a full turn
    f1 = fold(lat1_a);
    f2 = fold(lat2_a);
    fd = fold(dlon_a);
  end

  // rotation chains: 0 = start lat, 1 = end lat, 2 = dlon
  logic signed [SC_W-1:0] rx [3][ITER+1];
  logic signed [SC_W-1:0] ry [3][ITER+1];
  logic [AB-1:0]          rz [3][ITER+1];
  logic                   rn [3][ITER+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 3; g++) begin
        rx[g][0] <= GAIN_Q30;
        ry[g][0] <= '0;
      end
      rz[0][0] <= f1[AB-1:0];
      rn[0][0] <= f1[AB];
      rz[1][0] <= f2[AB-1:0];
      rn[1][0] <= f2[AB];
      rz[2][0] <= fd[AB-1:0];
      rn[2][0] <= fd[AB];
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_rot
    for (genvar i = 0; i < ITER; i++) begin : g_cell
      localparam logic [63:0] AT = atan_ang(i, AB);
      gcib_rot_cell #(
        .ANGLE_BITS(AB),
        .STAGE     (i),
        .ATAN      (AT[AB-1:0])
      ) u_cell (
        .clk    (clk),
        .en     (en),
        .x_in   (rx[g][i]),
        .y_in   (ry[g][i]),
        .z_in   (rz[g][i]),
        .neg_in (rn[g][i]),
        .x_out  (rx[g][i+1]),
        .y_out  (ry[g][i+1]),
        .z_out  (rz[g][i+1]),
        .neg_out(rn[g][i+1])
      );
    end
  end

  // sines and cosines, sign-corrected for a half-turn fold
  logic signed [SC_W-1:0] s1, c1, s2, c2, sd, cd;

  always_comb begin
    s1 = rn[0][ITER] ? -ry[0][ITER] : ry[0][ITER];
    c1 = rn[0][ITER] ? -rx[0][ITER] : rx[0][ITER];
    s2 = rn[1][ITER] ? -ry[1][ITER] : ry[1][ITER];
    c2 = rn[1][ITER] ? -rx[1][ITER] : rx[1][ITER];
    sd = rn[2][ITER] ? -ry[2][ITER] : ry[2][ITER];
    cd = rn[2][ITER] ? -rx[2][ITER] : rx[2][ITER];
  end

  // multiply stage 1: q60 products
  logic signed [2*SC_W-1:0] p_ny, p_c1s2, p_s1c2;
  logic signed [SC_W-1:0]   cd_m1;

  always_ff @(posedge clk) begin
    if (en) begin
      p_ny   <= sd * c2;
      p_c1s2 <= c1 * s2;
      p_s1c2 <= s1 * c2;
      cd_m1  <= cd;
    end
  end

  // multiply stage 2: (s1*c2 >> 30) * cos dlon
  logic signed [2*SC_W-1:0] s1c2_q30;
  logic signed [SC_W-1:0]   s1c2_n;
  logic signed [3*SC_W-1:0] p_tail;
  logic signed [VEC_W-1:0]  ny_m2, c1s2_m2;

  assign s1c2_q30 = p_s1c2 >>> 30;
  assign s1c2_n   = s1c2_q30[SC_W-1:0];  // q30, fits the sine/cosine width

  always_ff @(posedge clk) begin
    if (en) begin
      ny_m2   <= VEC_W'(p_ny >>> 20);
      c1s2_m2 <= VEC_W'(p_c1s2 >>> 20);
      p_tail  <= s1c2_n * cd_m1;
    end
  end

  // stage 3: cosine term of the bearing
  logic signed [VEC_W-1:0] ny_m3, nx_m3;
  logic signed [3*SC_W-1:0] tail_q40;

  assign tail_q40 = p_tail >>> 20;

  always_ff @(posedge clk) begin
    if (en) begin
      ny_m3 <= ny_m2;
      nx_m3 <= c1s2_m2 - VEC_W'(tail_q40);
    end
  end

  // vectoring chain, pre-rotated into the right half plane
  logic signed [VEC_W-1:0] vx [ITER+1];
  logic signed [VEC_W-1:0] vy [ITER+1];
  logic [AB-1:0]           vz [ITER+1];
  logic                    vzero [ITER+1];

  always_ff @(posedge clk) begin
    if (en) begin
      vzero[0] <= (nx_m3 == '0) && (ny_m3 == '0);
      if (nx_m3[VEC_W-1]) begin
        vx[0] <= -nx_m3;
        vy[0] <= -ny_m3;
        vz[0] <= HT[AB-1:0];
      end else begin
        vx[0] <= nx_m3;
        vy[0] <= ny_m3;
        vz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_vec
    localparam logic [63:0] AT = atan_ang(i, AB);
    gcib_vec_cell #(
      .ANGLE_BITS(AB),
      .STAGE     (i),
      .ATAN      (AT[AB-1:0])
    ) u_cell (
      .clk     (clk),
      .en      (en),
      .x_in    (vx[i]),
      .y_in    (vy[i]),
      .z_in    (vz[i]),
      .zero_in (vzero[i]),
      .x_out   (vx[i+1]),
      .y_out   (vy[i+1]),
      .z_out   (vz[i+1]),
      .zero_out(vzero[i+1])
    );
  end

  // output: round half up to 32 bits or shift up, zero for degenerate input
  logic [63:0] rw;
  logic        zero_o;

  assign rw = ({{(64-AB){1'b0}}, vz[ITER]} + HALFR) & AMASK;

  always_ff @(posedge clk) begin
    if (en) begin
      zero_o <= vzero[ITER];
      if (vzero[ITER]) begin
        initial_bearing <= '0;
      end else begin
        initial_bearing <= FIELD_BITS'((rw >> UPSH) << DNSH);
      end
    end
  end

  // an accepted beat enters the pipe
  `GCIB_ASSERT_NEXT(a_enter, clk, rst, in_valid && !in_stall, vld[0])
  // a held result freezes every stage
  `GCIB_ASSERT_NEXT(a_freeze, clk, rst, !en, $stable(vld))
  // degenerate geometry reads as zero
  `GCIB_ASSERT_NOW(a_zero, clk, rst, out_valid && zero_o, initial_bearing == '0)
  // operand handoff between the multiply stage and the rotation chain end
  `GCIB_ASSERT_NEXT(a_mult, clk, rst, en && vld[ROT_END-1], vld[ROT_END])
  // vectoring chain is fed only from a valid multiply result
  `GCIB_ASSERT_NEXT(a_vec, clk, rst, en && !vld[VEC_BEG-2], !vld[VEC_BEG-1])

endmodule

// File: bench/gcib_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gcib_checker
// watches both channels, predicts each bearing and compares it in order
// ----------------------------------------------------------------------------
module gcib_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] start_lat,
  input  logic signed [31:0] start_lon,
  input  logic signed [31:0] end_lat,
  input  logic signed [31:0] end_lon,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] initial_bearing,
  output int                 errors,
  output int                 pending,
  output int                 results_seen
);

  localparam int STAGES = 31;
  localparam longint HALF = 64'sd1 <<< 31;
  localparam longint QUART = 64'sd1 <<< 30;
  localparam longint GAIN = 64'sh26DD3B6A;

  longint atan_units [STAGES];
  logic signed [31:0] bearing_q [$];

  initial begin
    longint sum;
    longint term;
    logic [127:0] prod;
    logic [63:0] hi;
    for (int i = 0; i < STAGES; i++) begin
      if (i == 0) begin
        sum = 64'sh3243F6A8885A308D >>> 2;
      end else begin
        sum = 0;
        for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
          term = (64'sd1 <<< (60 - i * (2 * k + 1))) / (2 * k + 1);
          sum = (k % 2 == 1) ? sum - term : sum + term;
        end
      end
      prod = {64'd0, sum} * {64'd0, 64'hA2F9836E4E441529};
      hi = prod[127:64];
      atan_units[i] = longint'((hi + (64'd1 << 29)) >> 30);
    end
  end

  // rotation cordic, angle folded to within a quarter turn
  function automatic void rotate(input longint ang, output longint s, output longint c);
    longint x, y, z, nx;
    bit flip;
    x = GAIN; y = 0; z = ang; flip = 0;
    if (z > QUART) begin
      z -= HALF; flip = 1;
    end else if (z < -QUART) begin
      z += HALF; flip = 1;
    end
    for (int i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_units[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_units[i];
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic logic signed [31:0] bearing_of(logic signed [31:0] lat1,
      logic signed [31:0] lon1, logic signed [31:0] lat2, logic signed [31:0] lon2);
    logic signed [31:0] dl;
    longint s1, c1, s2, c2, sd, cd, ny, nx, z, tx;
    dl = lon2 - lon1;
    rotate(longint'(lat1), s1, c1);
    rotate(longint'(lat2), s2, c2);
    rotate(longint'(dl), sd, cd);
    ny = (sd * c2) >>> 20;
    nx = ((c1 * s2) >>> 20) - ((((s1 * c2) >>> 30) * cd) >>> 20);
    if (nx == 0 && ny == 0) return 32'sd0;
    z = 0;
    if (nx < 0) begin
      nx = -nx; ny = -ny; z = HALF;
    end
    for (int i = 0; i < STAGES; i++) begin
      if (ny >= 0) begin
        tx = nx + (ny >>> i); ny = ny - (nx >>> i); z += atan_units[i];
      end else begin
        tx = nx - (ny >>> i); ny = ny + (nx >>> i); z -= atan_units[i];
      end
      nx = tx;
    end
    return z[31:0];
  endfunction

  assign pending = bearing_q.size();

  always @(posedge clk) begin
    logic signed [31:0] want;
    if (rst) begin
      errors <= 0;
      results_seen <= 0;
    end else begin
      if (in_valid && !in_stall)
        bearing_q.push_back(bearing_of(start_lat, start_lon, end_lat, end_lon));
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (bearing_q.size() == 0) begin
          $error("initial_bearing: unexpected beat, actual %0d", initial_bearing);
          errors <= errors + 1;
        end else begin
          want = bearing_q.pop_front();
          if (want !== initial_bearing) begin
            $error("initial_bearing: expected %0d, actual %0d", want, initial_bearing);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the great-circle bearing pipeline
// ----------------------------------------------------------------------------
// Drives directed point pairs (poles, coincident points, due south, field
// extremes, longitude wrap) and then random pairs with bursty idling on both
// channels; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
  import gcib_pkg::*;

  localparam int N_RANDOM = 800;
  localparam int WATCHDOG = 3000;
  localparam logic signed [31:0] NORTH = 32'sh40000000;  // +90 degrees
  localparam logic signed [31:0] SOUTH = -32'sh40000000; // -90 degrees

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic out_stall = 0;
  logic signed [31:0] start_lat = 0, start_lon = 0, end_lat = 0, end_lon = 0;
  logic in_stall, out_valid;
  logic signed [31:0] initial_bearing;
  int errors, pending, results_seen;
  int idle_cycles = 0;
  bit calm = 0;      // last part of the run, no idling on either side
  bit done = 0;
  int sent = 0;

  always #10 clk = ~clk;

  great_circle_initial_bearing u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .start_lat(start_lat), .start_lon(start_lon),
    .end_lat(end_lat), .end_lon(end_lon),
    .out_valid(out_valid), .out_stall(out_stall),
    .initial_bearing(initial_bearing)
  );

  gcib_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .start_lat(start_lat), .start_lon(start_lon),
    .end_lat(end_lat), .end_lon(end_lon),
    .out_valid(out_valid), .out_stall(out_stall),
    .initial_bearing(initial_bearing),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  // random latitude within +-90 degrees inclusive
  function automatic logic signed [31:0] any_lat();
    longint v;
    v = longint'($urandom_range(32'h80000000, 0)) - 64'sd1073741824;
    return v[31:0];
  endfunction

  // present one beat and hold it until accepted; returns at the accepting edge
  task automatic send(logic signed [31:0] la1, logic signed [31:0] lo1,
                      logic signed [31:0] la2, logic signed [31:0] lo2);
    start_lat <= la1; start_lon <= lo1; end_lat <= la2; end_lon <= lo2;
    in_valid <= 1;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
      @(posedge clk);
    end
    @(posedge clk);
    sent++;
    // random gap burst before the next beat
    if (!calm && $urandom_range(3, 0) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
  endtask

  // receiver: bursty stall, one long hold-off so the pipe fills and backs up
  initial begin
    bit held;
    held = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && results_seen >= 100) begin
        held = 1;
        out_stall <= 1;
        repeat (300) @(posedge clk);
      end else if (calm) begin
        out_stall <= 0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(2, 0) == 0);
        repeat ($urandom_range(16, 1)) @(posedge clk);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst || done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired, %0d beats still expected", pending);
      $display("** great_circle_initial_bearing: FAILED **");
      $finish;
    end
  end

  initial begin
    int kind;
    logic signed [31:0] la, lo;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: coincident, poles, due south, extremes, longitude wrap
    send(0, 0, 0, 0);
    send(32'sh12345678, -32'sh7000000, 32'sh12345678, -32'sh7000000);
    send(NORTH, 0, 0, 32'sh10000000);
    send(SOUTH, 32'sh7FFFFFFF, 32'sh1000000, 32'sh80000000);
    send(0, 5, NORTH, 77);
    send(0, 0, SOUTH, 0);
    send(32'sh1000000, 32'sh100, -32'sh1000000, 32'sh100);
    send(0, 32'sh7FFFFFFF, 0, 32'sh80000000);
    send(0, 32'sh80000000, 0, 32'sh7FFFFFFF);
    send(0, 0, 0, 32'sh80000000);
    send(0, 0, 0, 32'sh40000000);
    send(0, 0, 0, -32'sh40000000);
    send(NORTH, 32'sh80000000, SOUTH, 32'sh7FFFFFFF);
    send(SOUTH, 0, NORTH, 0);
    send(32'sh3FFFFFFF, 32'shFFFFFFFF, -32'sh3FFFFFFF, 1);
    send(0, 0, 1, 0);
    send(0, 0, -1, 0);
    send(0, 0, 0, 1);
    send(32'sh20000000, -32'sh55555555, -32'sh20000000, 32'sh55555555);
    send(-32'sh2AAAAAAA, 32'sh0F0F0F0F, 32'sh2AAAAAAA, 32'shF0F0F0F0);

    // random pairs: mostly generic, some near-coincident, some near the poles
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - 100) calm = 1;
      kind = $urandom_range(9, 0);
      if (kind < 6) begin
        send(any_lat(), $urandom, any_lat(), $urandom);
      end else if (kind < 8) begin
        la = any_lat(); lo = $urandom;
        send(la, lo, la + $signed($urandom_range(511, 0)) - 256,
             lo + $signed($urandom_range(511, 0)) - 256);
      end else begin
        la = ($urandom_range(1, 0) != 0) ? NORTH : SOUTH;
        send(la - $urandom_range(1000, 0) * (la > 0 ? 1 : -1), $urandom,
             any_lat(), $urandom);
      end
    end
    in_valid <= 0;
    calm = 1;

    while (pending != 0) @(posedge clk);
    done = 1;
    repeat (100) @(posedge clk);
    $display("sent %0d point pairs, checked %0d bearings incl. poles, wrap and south",
             sent, results_seen);
    $display("idling bursts on both channels and one long receiver hold-off");
    if (errors == 0 && pending == 0)
      $display("** great_circle_initial_bearing: PASSED **");
    else
      $display("** great_circle_initial_bearing: FAILED **");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/gcib_pkg.sv
sv/gcib_rot_cell.sv
sv/gcib_vec_cell.sv
sv/great_circle_initial_bearing.sv
bench/gcib_checker.sv
bench/tb_top.sv
